// ----- rtl/core/fire_burn_grid_core_assert.svh -----
// Assertion macros used by the fire grid top level.
`ifndef FIRE_BURN_GRID_CORE_ASSERT_SVH
`define FIRE_BURN_GRID_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FBG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FBG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fbg_pkg.sv -----
// Package: types, constants and grid geometry for the fire grid core.
`timescale 1ns / 1ps
package fbg_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;

  localparam int COL_W     = $clog2(GRID_WIDTH);
  localparam int BASE_W    = COL_W + 2;
  localparam int DEN_CAP   = GRID_WIDTH * 7;
  localparam int DEN_W     = $clog2(DEN_CAP + 1);
  localparam int DEN_RESET = 4;
  localparam int DEN_STEP  = 10;

  // Rows are split by parity into two memories; row r lives at (r/2)*W + col.
  localparam int MEM_ROWS  = (GRID_HEIGHT + 6) / 2;
  localparam int MEM_DEPTH = MEM_ROWS * GRID_WIDTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int PAIRS      = GRID_HEIGHT / 2 + 1;
  localparam int PAIR_W     = $clog2(PAIRS);
  localparam int STEP_W     = $clog2(GRID_WIDTH + 2);
  localparam int VIS0_PAIRS = (GRID_HEIGHT + 1) / 2;
  localparam int VIS1_PAIRS = GRID_HEIGHT / 2;

  localparam int VIS_CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int SPARK_HALF = GRID_HEIGHT / 2;
  localparam logic SPARK_PAR = 1'(GRID_HEIGHT % 2);
  localparam int COL2_OFS   = (GRID_WIDTH * 3 / 2) % GRID_WIDTH;

  localparam logic [7:0] HOT_LEVEL = 8'd126;
  localparam logic [7:0] CELL_MAX  = 8'd255;

  // x/3 for x below 2^16
  localparam int RECIP3   = 43691;
  localparam int R3_SHIFT = 17;

  // pixel_index / GRID_WIDTH for a 12-bit index
  localparam int IDX_W     = 12;
  localparam int DIV_SHIFT = IDX_W + COL_W;
  localparam int DIV_MUL   = ((1 << DIV_SHIFT) + GRID_WIDTH - 1) / GRID_WIDTH;

  localparam logic [1:0] REQ_SPARK   = 2'd0;
  localparam logic [1:0] REQ_DIFFUSE = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       rand_first;
    logic [7:0]       rand_second;
    logic [IDX_W-1:0] pixel_index;
  } fbg_in_t;

  typedef struct packed {
    logic [8:0] density_now;
    logic       burn_done;
    logic       spark_taken;
    logic [7:0] alpha_out;
  } fbg_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPK_RD,
    ST_SPK_CALC,
    ST_SPK_WR2,
    ST_RD_DIV,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_DIFF,
    ST_FIN
  } fbg_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] top_addr;
    logic [ADDR_W-1:0] bot_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_even;
    logic [7:0]        wr_odd;
  } fbg_diff_port_t;

  typedef struct packed {
    logic busy;
    logic finish;
    logic all_hot;
  } fbg_diff_stat_t;

endpackage

// ----- rtl/core/fbg_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
`timescale 1ns / 1ps
module fbg_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [WIDTH-1:0]  rdata0,
  output logic [WIDTH-1:0]  rdata1
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata0_r;
  logic [WIDTH-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata0_r <= mem_r[raddr0];
    rdata1_r <= mem_r[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// ----- rtl/core/fbg_diffuse.sv -----
// Diffusion pass sequencer: walks row pairs, computes cells, tracks the burn check.
`timescale 1ns / 1ps
module fbg_diffuse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [7:0]             top_data,
  input  logic [7:0]             bot_data,
  output fbg_pkg::fbg_diff_port_t port,
  output fbg_pkg::fbg_diff_stat_t stat
);

  localparam int W = fbg_pkg::GRID_WIDTH;
  localparam int CW = fbg_pkg::COL_W;
  localparam int AW = fbg_pkg::ADDR_W;
  localparam int JW = fbg_pkg::STEP_W;
  localparam int PW = fbg_pkg::PAIR_W;

  // issue side
  logic          act_r;
  logic [JW-1:0] j_r;
  logic [PW-1:0] p_r;
  logic [AW-1:0] pbase_r;
  logic [CW-1:0] tcol_r;
  logic          all_hot_r;

  // response side (data lands in the cycle after the read)
  logic          rsp_v_r;
  logic          rsp_last_r;
  logic          rsp_calc_r;
  logic [CW-1:0] rsp_x_r;
  logic [AW-1:0] rsp_base_r;
  logic          rsp_vis0_r;
  logic          rsp_vis1_r;
  logic [7:0]    t0_r;
  logic [7:0]    t1_r;

  logic          j_last;
  logic          p_last;
  logic [CW-1:0] bcol;
  logic [9:0]    sum;
  logic [7:0]    c_raw;
  logic [7:0]    c_val;
  logic [8:0]    d_sum;
  logic [7:0]    d_val;
  logic          bad;

  assign j_last = (j_r == JW'(W + 1));
  assign p_last = (p_r == PW'(fbg_pkg::PAIRS - 1));
  assign bcol   = (j_r >= JW'(2)) ? CW'(j_r - JW'(2)) : '0;

  // top row sequence per pair: W-1, 0 .. W-1, 0 ; bottom follows 0 .. W-1 behind it
  assign port.top_addr = AW'(pbase_r + AW'(W) + AW'(tcol_r));
  assign port.bot_addr = AW'(pbase_r + AW'(2 * W) + AW'(bcol));

  always_comb begin
    sum   = 10'(t0_r) + 10'(t1_r) + 10'(top_data) + 10'(bot_data);
    c_raw = sum[9:2];
    c_val = (c_raw > 8'd1) ? c_raw - 8'd1 : c_raw;
    d_sum = 9'(c_val) + 9'(bot_data);
    d_val = d_sum[8:1];
    bad   = (rsp_vis0_r && (c_val < fbg_pkg::HOT_LEVEL)) ||
            (rsp_vis1_r && (d_val < fbg_pkg::HOT_LEVEL));
  end

  assign port.wr_en   = rsp_v_r && rsp_calc_r;
  assign port.wr_addr = AW'(rsp_base_r + AW'(rsp_x_r));
  assign port.wr_even = c_val;
  assign port.wr_odd  = d_val;

  assign stat.busy    = act_r || rsp_v_r;
  assign stat.finish  = rsp_v_r && rsp_last_r;
  assign stat.all_hot = all_hot_r && !(port.wr_en && bad);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r      <= 1'b0;
      rsp_v_r    <= 1'b0;
      rsp_last_r <= 1'b0;
      all_hot_r  <= 1'b0;
      j_r        <= '0;
      p_r        <= '0;
    end else begin
      rsp_v_r    <= act_r;
      rsp_last_r <= act_r && j_last && p_last;
      if (start) begin
        act_r     <= 1'b1;
        j_r       <= '0;
        p_r       <= '0;
        all_hot_r <= 1'b1;
      end else begin
        if (act_r) begin
          if (j_last) begin
            j_r <= '0;
            p_r <= p_r + PW'(1);
            if (p_last) begin
              act_r <= 1'b0;
            end
          end else begin
            j_r <= j_r + JW'(1);
          end
        end
        if (port.wr_en && bad) begin
          all_hot_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pbase_r <= '0;
      tcol_r  <= CW'(W - 1);
    end else if (act_r) begin
      if (j_last) begin
        pbase_r <= AW'(pbase_r + AW'(W));
        tcol_r  <= CW'(W - 1);
      end else begin
        tcol_r <= (tcol_r == CW'(W - 1)) ? '0 : tcol_r + CW'(1);
      end
    end
    rsp_calc_r <= (j_r >= JW'(2));
    rsp_x_r    <= bcol;
    rsp_base_r <= pbase_r;
    rsp_vis0_r <= (32'(p_r) < fbg_pkg::VIS0_PAIRS);
    rsp_vis1_r <= (32'(p_r) < fbg_pkg::VIS1_PAIRS);
    if (rsp_v_r) begin
      t0_r <= t1_r;
      t1_r <= top_data;
    end
  end

endmodule

// ----- rtl/core/fire_burn_grid_core.sv -----
// Fire grid top level: control sequencer, spark and read datapath, grid memories.
// Request flow: spark SPK_RD, SPK_CALC, SPK_WR2, FIN (FIN alone when the frame quota is used),
// read RD_DIV, RD_ADDR, RD_DATA, FIN, unknown FIN alone, diffuse DIFF until the pass ends, then FIN.
// Throughput: one item at a time; a diffuse pass walks GRID_HEIGHT/2+1 row pairs.
// Reset: synchronous, active low; afterwards a clearing pass over all MEM_DEPTH addresses
// (2240 at 64x64) zeroes both memories while in_stall stays high.
`timescale 1ns / 1ps
`include "fire_burn_grid_core_assert.svh"
module fire_burn_grid_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fbg_pkg::fbg_in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output fbg_pkg::fbg_out_t out_data
);

  localparam int W  = fbg_pkg::GRID_WIDTH;
  localparam int CW = fbg_pkg::COL_W;
  localparam int AW = fbg_pkg::ADDR_W;
  localparam int DW = fbg_pkg::DEN_W;
  localparam int BW = fbg_pkg::BASE_W;
  localparam int IW = fbg_pkg::IDX_W;

  fbg_pkg::fbg_state_t state_r, state_nxt;

  logic [AW-1:0] clr_addr_r;
  logic [DW-1:0] density_r;
  logic [BW-1:0] base_r;
  logic [CW-1:0] count_r;
  logic          done_r;
  logic          taken_r;
  logic [7:0]    alpha_r;
  logic [CW-1:0] col_r;
  logic [7:0]    r1_r;
  logic [7:0]    r2_r;
  logic [7:0]    v_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] row_r;
  logic          out_valid_r;
  fbg_pkg::fbg_out_t out_data_r;

  logic          accept;
  logic          out_free;
  logic          quota_ok;
  logic [CW:0]   col_sum;
  logic [CW-1:0] col_nxt;
  logic [CW:0]   col2_sum;
  logic [CW-1:0] col2;
  logic [AW-1:0] spk_addr0;
  logic [AW-1:0] spk_addr1;
  logic [AW-1:0] rd_addr;
  logic          rd_in_range;
  logic [AW-1:0] acc_addr;
  logic [7:0]    acc_data;
  logic [9:0]    v_sum;
  logic [7:0]    v_calc;
  logic [31:0]   q3;
  logic [DW:0]   den_sum;
  logic [DW-1:0] density_nxt;
  logic [31:0]   row_prod;
  logic [IW-1:0] rd_half;
  logic          diff_start;

  logic          even_we, odd_we;
  logic [AW-1:0] even_wa, odd_wa;
  logic [7:0]    even_wd, odd_wd;
  logic [AW-1:0] even_ra0;
  logic [7:0]    even_rd0, even_rd1, odd_rd0, odd_rd1;

  fbg_pkg::fbg_diff_port_t diff_port;
  fbg_pkg::fbg_diff_stat_t diff_stat;

  assign in_stall  = (state_r != fbg_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign diff_start = accept && (in_data.req_type == fbg_pkg::REQ_DIFFUSE);

  // spark column and its partner, shifted by half the grid width, on the lower feed row
  assign quota_ok = (DW'(count_r) < (density_r >> 3));
  assign col_sum  = (CW+1)'(count_r) + (CW+1)'(base_r);
  assign col_nxt  = (col_sum >= (CW+1)'(W)) ? CW'(col_sum - (CW+1)'(W)) : CW'(col_sum);
  assign col2_sum = (CW+1)'(col_r) + (CW+1)'(fbg_pkg::COL2_OFS);
  assign col2     = (col2_sum >= (CW+1)'(W)) ? CW'(col2_sum - (CW+1)'(W)) : CW'(col2_sum);

  assign spk_addr0 = AW'(fbg_pkg::SPARK_HALF * W) + AW'(col_r);
  assign spk_addr1 = AW'((fbg_pkg::SPARK_HALF + 1) * W) + AW'(col2);

  // read address: idx - ceil(row/2)*W maps a visible cell into its parity memory
  assign rd_in_range = (32'(idx_r) < fbg_pkg::VIS_CELLS);
  assign rd_half     = IW'((13'(row_r) + 13'd1) >> 1);
  assign rd_addr     = rd_in_range ? AW'(32'(idx_r) - 32'(rd_half) * 32'(W)) : '0;
  assign row_prod    = 32'(idx_r) * 32'(fbg_pkg::DIV_MUL);

  assign acc_addr = (state_r == fbg_pkg::ST_RD_ADDR || state_r == fbg_pkg::ST_RD_DATA) ?
                    rd_addr : spk_addr0;
  assign acc_data = (state_r == fbg_pkg::ST_RD_DATA) ?
                    (row_r[0] ? odd_rd0 : even_rd0) :
                    (fbg_pkg::SPARK_PAR ? odd_rd1 : even_rd0);

  assign v_sum  = 10'(acc_data) + 10'd4 + 10'(r1_r[3:0]) + 10'(r1_r[7:3]) + 10'(r2_r[4:0]);
  assign v_calc = (v_sum > 10'(fbg_pkg::CELL_MAX)) ? fbg_pkg::CELL_MAX : v_sum[7:0];

  assign q3          = (32'(density_r) * 32'(fbg_pkg::RECIP3)) >> fbg_pkg::R3_SHIFT;
  assign den_sum     = (DW+1)'(density_r) + (DW+1)'(fbg_pkg::DEN_STEP);
  assign density_nxt = (den_sum > (DW+1)'(fbg_pkg::DEN_CAP)) ?
                       DW'(fbg_pkg::DEN_CAP) : DW'(den_sum);

  // memory port steering
  always_comb begin
    even_we  = 1'b0;
    odd_we   = 1'b0;
    even_wa  = diff_port.wr_addr;
    odd_wa   = diff_port.wr_addr;
    even_wd  = diff_port.wr_even;
    odd_wd   = diff_port.wr_odd;
    even_ra0 = (state_r == fbg_pkg::ST_DIFF) ? diff_port.top_addr : acc_addr;
    unique case (state_r)
      fbg_pkg::ST_CLEAR: begin
        even_we = 1'b1;
        odd_we  = 1'b1;
        even_wa = clr_addr_r;
        odd_wa  = clr_addr_r;
        even_wd = '0;
        odd_wd  = '0;
      end
      fbg_pkg::ST_DIFF: begin
        even_we = diff_port.wr_en;
        odd_we  = diff_port.wr_en;
      end
      fbg_pkg::ST_SPK_CALC: begin
        even_we = !fbg_pkg::SPARK_PAR;
        odd_we  = fbg_pkg::SPARK_PAR;
        even_wa = spk_addr0;
        odd_wa  = spk_addr0;
        even_wd = v_calc;
        odd_wd  = v_calc;
      end
      fbg_pkg::ST_SPK_WR2: begin
        even_we = !fbg_pkg::SPARK_PAR;
        odd_we  = fbg_pkg::SPARK_PAR;
        even_wa = spk_addr1;
        odd_wa  = spk_addr1;
        even_wd = v_r;
        odd_wd  = v_r;
      end
      default: begin
      end
    endcase
  end

  fbg_ram #(
    .WIDTH  (8),
    .DEPTH  (fbg_pkg::MEM_DEPTH),
    .ADDR_W (AW)
  ) u_even_ram (
    .clk    (clk),
    .we     (even_we),
    .waddr  (even_wa),
    .wdata  (even_wd),
    .raddr0 (even_ra0),
    .raddr1 (diff_port.bot_addr),
    .rdata0 (even_rd0),
    .rdata1 (even_rd1)
  );

  fbg_ram #(
    .WIDTH  (8),
    .DEPTH  (fbg_pkg::MEM_DEPTH),
    .ADDR_W (AW)
  ) u_odd_ram (
    .clk    (clk),
    .we     (odd_we),
    .waddr  (odd_wa),
    .wdata  (odd_wd),
    .raddr0 (acc_addr),
    .raddr1 (acc_addr),
    .rdata0 (odd_rd0),
    .rdata1 (odd_rd1)
  );

  fbg_diffuse u_diffuse (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (diff_start),
    .top_data (even_rd0),
    .bot_data (even_rd1),
    .port     (diff_port),
    .stat     (diff_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbg_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fbg_pkg::ST_CLEAR: begin
        if (clr_addr_r == AW'(fbg_pkg::MEM_DEPTH - 1)) begin
          state_nxt = fbg_pkg::ST_IDLE;
        end
      end
      fbg_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_data.req_type)
            fbg_pkg::REQ_SPARK:   state_nxt = quota_ok ? fbg_pkg::ST_SPK_RD : fbg_pkg::ST_FIN;
            fbg_pkg::REQ_DIFFUSE: state_nxt = fbg_pkg::ST_DIFF;
            fbg_pkg::REQ_READ:    state_nxt = fbg_pkg::ST_RD_DIV;
            default:              state_nxt = fbg_pkg::ST_FIN;
          endcase
        end
      end
      fbg_pkg::ST_SPK_RD:   state_nxt = fbg_pkg::ST_SPK_CALC;
      fbg_pkg::ST_SPK_CALC: state_nxt = fbg_pkg::ST_SPK_WR2;
      fbg_pkg::ST_SPK_WR2:  state_nxt = fbg_pkg::ST_FIN;
      fbg_pkg::ST_RD_DIV:   state_nxt = fbg_pkg::ST_RD_ADDR;
      fbg_pkg::ST_RD_ADDR:  state_nxt = fbg_pkg::ST_RD_DATA;
      fbg_pkg::ST_RD_DATA:  state_nxt = fbg_pkg::ST_FIN;
      fbg_pkg::ST_DIFF: begin
        if (diff_stat.finish) begin
          state_nxt = fbg_pkg::ST_FIN;
        end
      end
      fbg_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = fbg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fbg_pkg::ST_CLEAR;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      density_r   <= DW'(fbg_pkg::DEN_RESET);
      base_r      <= '0;
      count_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == fbg_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (diff_start) begin
        base_r    <= BW'(base_r + BW'(q3));
        density_r <= density_nxt;
        count_r   <= '0;
      end else if (base_r >= BW'(W)) begin
        // wrap the advanced base back into range while the pass runs
        base_r <= base_r - BW'(W);
      end
      if (state_r == fbg_pkg::ST_SPK_WR2) begin
        count_r <= count_r + CW'(1);
      end
      if (state_r == fbg_pkg::ST_DIFF && diff_stat.finish && diff_stat.all_hot) begin
        done_r <= 1'b1;
      end
      if (state_r == fbg_pkg::ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      taken_r <= 1'b0;
      alpha_r <= '0;
      col_r   <= col_nxt;
      r1_r    <= in_data.rand_first;
      r2_r    <= in_data.rand_second;
      idx_r   <= in_data.pixel_index;
    end
    if (state_r == fbg_pkg::ST_SPK_CALC) begin
      v_r <= v_calc;
    end
    if (state_r == fbg_pkg::ST_SPK_WR2) begin
      taken_r <= 1'b1;
    end
    if (state_r == fbg_pkg::ST_RD_DIV) begin
      row_r <= IW'(row_prod >> fbg_pkg::DIV_SHIFT);
    end
    if (state_r == fbg_pkg::ST_RD_DATA && rd_in_range) begin
      alpha_r <= acc_data[7] ? fbg_pkg::CELL_MAX : {acc_data[6:0], 1'b0};
    end
    if (state_r == fbg_pkg::ST_FIN && out_free) begin
      out_data_r.density_now <= 9'(density_r);
      out_data_r.burn_done   <= done_r;
      out_data_r.spark_taken <= taken_r;
      out_data_r.alpha_out   <= alpha_r;
    end
  end

  `FBG_ASSERT_NOW(a_pass_in_diff, diff_stat.busy, state_r == fbg_pkg::ST_DIFF, "diffusion pass outside diffuse state")
  `FBG_ASSERT_NOW(a_quota, state_r != fbg_pkg::ST_CLEAR, DW'(count_r) <= (density_r >> 3), "spark count above frame quota")
  `FBG_ASSERT_NOW(a_den_cap, 1'b1, density_r <= DW'(fbg_pkg::DEN_CAP), "density above cap")
  `FBG_ASSERT_NOW(a_base_wrapped, state_r == fbg_pkg::ST_IDLE, base_r < BW'(W), "spark base not reduced when idle")
  `FBG_ASSERT_NEXT(a_fin_done, diff_stat.finish, state_r == fbg_pkg::ST_FIN, "pass end did not reach result stage")

endmodule
